/* src/vfvs_pkg.sv */
// Shared types and constants for the voxel face visibility store.
// No dependencies; imported by the top level and vfvs_ctrl.
package vfvs_pkg;

   // Command codes
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CULL  = 2'd2;

   // Face mask bit positions
   localparam int FACE_PZ = 0;
   localparam int FACE_NZ = 1;
   localparam int FACE_NX = 2;
   localparam int FACE_PX = 3;
   localparam int FACE_PY = 4;
   localparam int FACE_NY = 5;

   // One result transaction
   typedef struct packed {
      logic [7:0] read_type;
      logic [5:0] face_mask;
      logic       out_of_range;
   } rsp_type;

endpackage

/* src/voxel_face_visibility_store.sv */
// Voxel face visibility store. Holds a SIZE_X x SIZE_Y x SIZE_Z grid of 8-bit
// block types in a single-write, dual-read memory and handles one transaction
// at a time: an off-grid or unused command skips the memory access; a write
// is the shortest access, a read longer, a cull query the longest. The cull
// query time is set by the two memory read ports: the cell and its six
// neighbors are seven reads, two at a time, with registered data. The result
// sits in an output register, so the next transaction is accepted while it
// waits to be taken. air_type is written through csr_wr_en/csr_wr_data and
// must only change while no transaction is in flight. Cells read before being
// written return undefined data. Depends on vfvs_pkg, vfvs_ctrl, vfvs_cell_mem.
module voxel_face_visibility_store import vfvs_pkg::*; #(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 16,
   parameter int SIZE_Z = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic signed [5:0] req_pos_x,
   input  logic signed [5:0] req_pos_y,
   input  logic signed [5:0] req_pos_z,
   input  logic [7:0]        req_new_type,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_type,
   output logic [5:0]        rsp_face_mask,
   output logic              rsp_out_of_range,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   localparam int DEPTH  = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0]        air_type_ff, air_type_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              done_valid;
   logic              done_ready;
   rsp_type           done;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr_a;
   logic [ADDR_W-1:0] mem_rd_addr_b;
   logic [7:0]        mem_rd_data_a;
   logic [7:0]        mem_rd_data_b;

   vfvs_ctrl #(
      .SIZE_X (SIZE_X),
      .SIZE_Y (SIZE_Y),
      .SIZE_Z (SIZE_Z),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_new_type  (req_new_type),
      .air_type      (air_type_ff),
      .done_valid    (done_valid),
      .done_ready    (done_ready),
      .done          (done),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr_a (mem_rd_addr_a),
      .mem_rd_addr_b (mem_rd_addr_b),
      .mem_rd_data_a (mem_rd_data_a),
      .mem_rd_data_b (mem_rd_data_b)
   );

   vfvs_cell_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_cell_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   assign air_type_in = csr_wr_en ? csr_wr_data : air_type_ff;

   // Output register takes a new result when empty or drained this cycle.
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         air_type_ff  <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         air_type_ff  <= air_type_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_type    = rsp_data_ff.read_type;
   assign rsp_face_mask    = rsp_data_ff.face_mask;
   assign rsp_out_of_range = rsp_data_ff.out_of_range;

endmodule

/* src/vfvs_cell_mem.sv */
// Cell store: one write port, two registered read ports.
// Stand-alone; sized by the top level.
module vfvs_cell_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [7:0]        rd_data_a,
   output logic [7:0]        rd_data_b
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* src/vfvs_ctrl.sv */
// Command sequencer: address generation, memory access schedule, face mask build.
// Depends on vfvs_pkg; drives vfvs_cell_mem.
module vfvs_ctrl import vfvs_pkg::*; #(
   parameter int SIZE_X = 16,
   parameter int SIZE_Y = 16,
   parameter int SIZE_Z = 16,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic signed [5:0] req_pos_x,
   input  logic signed [5:0] req_pos_y,
   input  logic signed [5:0] req_pos_z,
   input  logic [7:0]        req_new_type,
   input  logic [7:0]        air_type,
   output logic              done_valid,
   input  logic              done_ready,
   output rsp_type           done,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [7:0]        mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr_a,
   output logic [ADDR_W-1:0] mem_rd_addr_b,
   input  logic [7:0]        mem_rd_data_a,
   input  logic [7:0]        mem_rd_data_b
);

   localparam logic [4:0] SX_C    = 5'(SIZE_X);
   localparam logic [4:0] SY_C    = 5'(SIZE_Y);
   localparam logic [4:0] SZ_C    = 5'(SIZE_Z);
   localparam logic [4:0] SX_LAST = 5'(SIZE_X - 1);
   localparam logic [4:0] SY_LAST = 5'(SIZE_Y - 1);
   localparam logic [4:0] SZ_LAST = 5'(SIZE_Z - 1);
   localparam logic [ADDR_W-1:0] STEP_X = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] STEP_Z = ADDR_W'(SIZE_X);
   localparam logic [ADDR_W-1:0] STEP_Y = ADDR_W'(SIZE_X * SIZE_Z);
   localparam logic [2:0] PHASE_LAST = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ADDR   = 4'b0010,
      S_ACCESS = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [4:0]        x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [7:0]        new_type_ff, new_type_in;
   logic              oor_ff, oor_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [5:0]        nb_ff, nb_in;       // neighbor lies inside the grid
   logic [2:0]        cnt_ff, cnt_in;
   logic [7:0]        read_type_ff, read_type_in;
   logic [5:0]        mask_ff, mask_in;
   logic              center_air_ff, center_air_in;

   logic accept;
   logic in_grid;
   logic air_a, air_b;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_grid   = !req_pos_x[5] && (req_pos_x[4:0] < SX_C) &&
                      !req_pos_y[5] && (req_pos_y[4:0] < SY_C) &&
                      !req_pos_z[5] && (req_pos_z[4:0] < SZ_C);
   assign air_a = (mem_rd_data_a == air_type);
   assign air_b = (mem_rd_data_b == air_type);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      new_type_in   = new_type_ff;
      oor_in        = oor_ff;
      addr_in       = addr_ff;
      nb_in         = nb_ff;
      cnt_in        = cnt_ff;
      read_type_in  = read_type_ff;
      mask_in       = mask_ff;
      center_air_in = center_air_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd;
               x_in          = req_pos_x[4:0];
               y_in          = req_pos_y[4:0];
               z_in          = req_pos_z[4:0];
               new_type_in   = req_new_type;
               oor_in        = !in_grid && (req_cmd == CMD_WRITE || req_cmd == CMD_READ ||
                                            req_cmd == CMD_CULL);
               read_type_in  = 8'd0;
               mask_in       = 6'd0;
               center_air_in = 1'b1;
               state_in      = S_ADDR;
            end
         end
         S_ADDR: begin
            addr_in = ADDR_W'(x_ff) + ADDR_W'(int'(z_ff) * SIZE_X) +
                      ADDR_W'(int'(y_ff) * SIZE_X * SIZE_Z);
            nb_in[FACE_PZ] = (z_ff != SZ_LAST);
            nb_in[FACE_NZ] = (z_ff != 5'd0);
            nb_in[FACE_NX] = (x_ff != 5'd0);
            nb_in[FACE_PX] = (x_ff != SX_LAST);
            nb_in[FACE_PY] = (y_ff != SY_LAST);
            nb_in[FACE_NY] = (y_ff != 5'd0);
            cnt_in = 3'd0;
            if (oor_ff || !(cmd_ff == CMD_WRITE || cmd_ff == CMD_READ ||
                            cmd_ff == CMD_CULL)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            cnt_in = cnt_ff + 3'd1;
            // read data of the previous phase arrives now
            case (cnt_ff)
               3'd1: begin
                  read_type_in    = (cmd_ff == CMD_READ) ? mem_rd_data_a : 8'd0;
                  center_air_in   = air_a;
                  mask_in[FACE_PZ] = !nb_ff[FACE_PZ] || air_b;
               end
               3'd2: begin
                  mask_in[FACE_NZ] = !nb_ff[FACE_NZ] || air_a;
                  mask_in[FACE_NX] = !nb_ff[FACE_NX] || air_b;
               end
               3'd3: begin
                  mask_in[FACE_PX] = !nb_ff[FACE_PX] || air_a;
                  mask_in[FACE_PY] = !nb_ff[FACE_PY] || air_b;
               end
               3'd4: begin
                  mask_in[FACE_NY] = !nb_ff[FACE_NY] || air_a;
               end
               default: begin
               end
            endcase
            if ((cmd_ff == CMD_WRITE) ||
                (cmd_ff == CMD_READ && cnt_ff == 3'd1) ||
                (cnt_ff == PHASE_LAST)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      new_type_ff   <= new_type_in;
      oor_ff        <= oor_in;
      addr_ff       <= addr_in;
      nb_ff         <= nb_in;
      cnt_ff        <= cnt_in;
      read_type_ff  <= read_type_in;
      mask_ff       <= mask_in;
      center_air_ff <= center_air_in;
   end

   // Items are serialized, so a write lands well before any later read.
   assign mem_wr_en   = (state_ff == S_ACCESS) && (cmd_ff == CMD_WRITE);
   assign mem_wr_addr = addr_ff;
   assign mem_wr_data = new_type_ff;
   assign mem_rd_en   = (state_ff == S_ACCESS) &&
                        ((cmd_ff == CMD_READ && cnt_ff == 3'd0) ||
                         (cmd_ff == CMD_CULL && cnt_ff != PHASE_LAST));

   // Seven reads over two ports; a neighbor off the grid reads the center instead.
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            mem_rd_addr_a = addr_ff;
            mem_rd_addr_b = nb_ff[FACE_PZ] ? addr_ff + STEP_Z : addr_ff;
         end
         2'd1: begin
            mem_rd_addr_a = nb_ff[FACE_NZ] ? addr_ff - STEP_Z : addr_ff;
            mem_rd_addr_b = nb_ff[FACE_NX] ? addr_ff - STEP_X : addr_ff;
         end
         2'd2: begin
            mem_rd_addr_a = nb_ff[FACE_PX] ? addr_ff + STEP_X : addr_ff;
            mem_rd_addr_b = nb_ff[FACE_PY] ? addr_ff + STEP_Y : addr_ff;
         end
         default: begin
            mem_rd_addr_a = nb_ff[FACE_NY] ? addr_ff - STEP_Y : addr_ff;
            mem_rd_addr_b = addr_ff;
         end
      endcase
   end

   assign done_valid        = (state_ff == S_DONE);
   assign done.read_type    = read_type_ff;
   assign done.face_mask    = (cmd_ff == CMD_CULL && !center_air_ff) ? mask_ff : 6'd0;
   assign done.out_of_range = oor_ff;

`ifndef ASSERT_OFF
   a_no_wr_rd_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("cell store written and read in the same cycle");

   a_wr_in_grid: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !oor_ff && cmd_ff == CMD_WRITE)
      else $error("write issued for an off-grid or non-write transaction");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      done_valid && done.out_of_range |-> done.read_type == 8'd0 && done.face_mask == 6'd0)
      else $error("off-grid result carries nonzero data");

   a_mask_cull_only: assert property (@(posedge clock) disable iff (reset)
      done_valid && cmd_ff != CMD_CULL |-> done.face_mask == 6'd0)
      else $error("face mask set on a non-cull transaction");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACCESS |-> cnt_ff <= PHASE_LAST)
      else $error("access phase counter overran");
`endif

endmodule
